// ===== sv/txrc_pkg.sv =====
// Shared types and constants for the transmit ring DMA chunker.
`timescale 1ns / 1ps
package txrc_pkg;

	// Ring geometry: depth must be a power of two, index arithmetic wraps naturally.
	localparam int BUFFER_DEPTH = 4096;
	localparam int IDX_W        = $clog2(BUFFER_DEPTH);

	// Fixed field widths of the request and result channels.
	localparam int DATA_W = 8;
	localparam int LEN_W  = 8;
	localparam int FIDX_W = 12;
	localparam int OFS_W  = 12;
	localparam int OCC_W  = 12;

	localparam logic [LEN_W-1:0] MAX_CHUNK_RST = 8'd255;

	typedef enum logic [1:0] {
		KIND_ENQ   = 2'd0,
		KIND_KICK  = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_FETCH = 2'd3
	} kind_t;

	// Classified request handed from front to back.
	typedef struct packed {
		kind_t              kind;
		logic [DATA_W-1:0]  data_byte;
		logic [LEN_W-1:0]   amount_sent;
		logic [IDX_W-1:0]   fetch_addr;
		logic               fetch_ok;
	} op_t;

	// Result fields held in the back end's output register.
	typedef struct packed {
		logic               accepted;
		logic               chunk_start;
		logic [OFS_W-1:0]   chunk_offset;
		logic [LEN_W-1:0]   chunk_length;
		logic               busy_res;
		logic [OCC_W-1:0]   occupancy;
		logic               fetch_hit;
	} res_t;

endpackage

// ===== sv/txrc_if.sv =====
// Channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps
interface txrc_req_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              kind;
	logic [7:0]              data_byte;
	logic [7:0]              amount_sent;
	logic [11:0]             fetch_index;

	modport source (output valid, kind, data_byte, amount_sent, fetch_index, input ready);
	modport sink   (input valid, kind, data_byte, amount_sent, fetch_index, output ready);
endinterface

interface txrc_res_if;
	logic                    valid;
	logic                    ready;
	logic                    accepted;
	logic                    chunk_start;
	logic [11:0]             chunk_offset;
	logic [7:0]              chunk_length;
	logic                    busy_res;
	logic [7:0]              fetched_byte;
	logic [11:0]             occupancy;

	modport source (output valid, accepted, chunk_start, chunk_offset, chunk_length,
		busy_res, fetched_byte, occupancy, input ready);
	modport sink   (input valid, accepted, chunk_start, chunk_offset, chunk_length,
		busy_res, fetched_byte, occupancy, output ready);
endinterface

interface txrc_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [7:0]              max_chunk;

	modport source (output valid, max_chunk, input ready);
	modport sink   (input valid, max_chunk, output ready);
endinterface

// ===== sv/txrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module txrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/txrc_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module txrc_front import txrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	txrc_req_if.sink     req,
	output logic         op_valid,
	output op_t          op,
	input  logic         op_pop
);

	op_t        ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	op_t        op_in;
	logic       push;

	always_comb begin
		op_in.kind        = kind_t'(req.kind);
		op_in.data_byte   = req.data_byte;
		op_in.amount_sent = req.amount_sent;
		op_in.fetch_addr  = IDX_W'(req.fetch_index);
		op_in.fetch_ok    = (32'(req.fetch_index) < 32'(BUFFER_DEPTH));
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign op_valid  = (cnt_q != 2'd0);
	assign op        = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, op_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/txrc_back.sv =====
// Back end: ring pointers, chunk launch logic, byte store and result register.
`timescale 1ns / 1ps
module txrc_back import txrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         op_valid,
	input  op_t          op,
	output logic         op_pop,
	txrc_cfg_if.sink     cfg,
	txrc_res_if.source   res
);

	localparam int AW = (IDX_W > LEN_W) ? IDX_W : LEN_W;
	localparam int RW = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
	localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(BUFFER_DEPTH);

	logic [IDX_W-1:0] head_q, tail_q;
	logic             active_q;
	logic [LEN_W-1:0] max_chunk_q;
	logic             res_valid_q;
	res_t             res_q;

	logic [IDX_W-1:0] head_d, tail_d, count, count_d, head_inc;
	logic             active_d, launch, full;
	logic [AW-1:0]    adv_w;
	logic [IDX_W-1:0] adv;
	logic [IDX_W:0]   run;
	logic [LEN_W-1:0] cap, length;
	logic [RW-1:0]    run_w, cap_w;
	logic             ram_we, ram_re;
	logic [DATA_W-1:0] ram_rdata;
	res_t             res_d;

	assign op_pop    = op_valid && (!res_valid_q || res.ready);
	assign count     = head_q - tail_q;
	assign head_inc  = head_q + IDX_W'(1);
	assign full      = (head_inc == tail_q);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		active_d = active_q;
		launch   = 1'b0;
		adv_w    = '0;
		adv      = '0;
		case (op.kind)
			KIND_ENQ: begin
				if (!full) begin
					head_d = head_inc;
				end
			end
			KIND_KICK: begin
				if (!active_q && count != '0) begin
					active_d = 1'b1;
					launch   = 1'b1;
				end
			end
			KIND_DONE: begin
				if (active_q) begin
					// retire at most what the ring holds
					adv_w = (AW'(op.amount_sent) > AW'(count)) ? AW'(count)
						: AW'(op.amount_sent);
					adv    = IDX_W'(adv_w);
					tail_d = tail_q + adv;
					if (count != adv) begin
						launch = 1'b1;
					end else begin
						active_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign count_d = head_d - tail_d;

	// chunk: from tail to head or to buffer end, capped
	always_comb begin
		if (head_d >= tail_d) begin
			run = {1'b0, head_d - tail_d};
		end else begin
			run = DEPTH_C - {1'b0, tail_d};
		end
		cap    = (max_chunk_q == '0) ? LEN_W'(1) : max_chunk_q;
		run_w  = RW'(run);
		cap_w  = RW'(cap);
		length = (run_w > cap_w) ? cap : LEN_W'(run_w);
	end

	always_comb begin
		res_d.accepted     = (op.kind == KIND_ENQ) && !full;
		res_d.chunk_start  = launch;
		res_d.chunk_offset = launch ? OFS_W'(tail_d) : '0;
		res_d.chunk_length = launch ? length : '0;
		res_d.busy_res     = active_d;
		res_d.occupancy    = OCC_W'(count_d);
		res_d.fetch_hit    = (op.kind == KIND_FETCH) && op.fetch_ok;
	end

	assign ram_we = op_pop && (op.kind == KIND_ENQ) && !full;
	assign ram_re = op_pop && (op.kind == KIND_FETCH);

	txrc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_q),
		.wdata(op.data_byte),
		.re   (ram_re),
		.raddr(op.fetch_addr),
		.rdata(ram_rdata)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			active_q    <= 1'b0;
			max_chunk_q <= MAX_CHUNK_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				max_chunk_q <= cfg.max_chunk;
			end
			if (op_pop) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				active_q <= active_d;
			end
			if (op_pop) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			res_q <= res_d;
		end
	end

	// read data stays put while the result waits: no new read until it is taken
	assign res.valid        = res_valid_q;
	assign res.accepted     = res_q.accepted;
	assign res.chunk_start  = res_q.chunk_start;
	assign res.chunk_offset = res_q.chunk_offset;
	assign res.chunk_length = res_q.chunk_length;
	assign res.busy_res     = res_q.busy_res;
	assign res.occupancy    = res_q.occupancy;
	assign res.fetched_byte = res_q.fetch_hit ? ram_rdata : '0;

endmodule

// ===== sv/tx_ring_dma_chunker.sv =====
// Top level of the transmit ring buffer with DMA chunking.
`timescale 1ns / 1ps
// Transmit ring of BUFFER_DEPTH bytes (holds one fewer) feeding a DMA engine in
// chunks. Each request (enqueue, kick, chunk done, fetch) yields exactly one
// result, in order. Throughput is one request per cycle sustained while results
// are taken as they come. An accepted request passes through the front queue
// into the result register; the registered read port of the byte store is
// loaded at the same edge as the result register and adds nothing. The front
// end takes requests into a two-entry queue, so req.ready only drops when that
// queue is full; the back end retires one queued request per cycle whenever its
// result register is empty or being drained. The store needs no clearing after
// reset if only written slots are ever read; the user must ensure that, the
// block does not enforce it. Chunks run from the tail to the head or the buffer
// end, capped at max_chunk (0 acts as 1). cfg.ready is always high; write
// max_chunk only while no request is in flight.
module tx_ring_dma_chunker import txrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	txrc_req_if.sink     req,
	txrc_cfg_if.sink     cfg,
	txrc_res_if.source   res
);

	// front to back request queue head
	logic op_valid;
	logic op_pop;
	op_t  op;

	txrc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.op_valid(op_valid),
		.op      (op),
		.op_pop  (op_pop)
	);

	txrc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_valid(op_valid),
		.op      (op),
		.op_pop  (op_pop),
		.cfg     (cfg),
		.res     (res)
	);

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the transmit ring DMA chunker.
`timescale 1ns / 1ps
module testbench;
	import txrc_pkg::*;

	// Quiet cycles (no request, result or config write accepted) before giving up.
	localparam int STALL_LIMIT = 1000;
	// Idle cycles after the last result before calling the run done.
	localparam int SETTLE_CYCLES = 8;
	// Idle cycles before a max_chunk write, as a margin after the last result.
	localparam int CFG_GUARD_CYCLES = 4;
	// Only the first REPORT_LINES mismatches are printed; all of them are counted.
	localparam int REPORT_LINES = 50;

	// One expected or observed result, same fields as the result channel.
	typedef struct packed {
		logic               accepted;
		logic               chunk_start;
		logic [OFS_W-1:0]   chunk_offset;
		logic [LEN_W-1:0]   chunk_length;
		logic               busy_res;
		logic [DATA_W-1:0]  fetched_byte;
		logic [OCC_W-1:0]   occupancy;
	} chunker_result_t;

	logic clk = 1'b0;
	logic arst_n;

	txrc_req_if req_ch ();
	txrc_res_if res_ch ();
	txrc_cfg_if cfg_ch ();

	tx_ring_dma_chunker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.res    (res_ch)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the ring: indexes, DMA state, chunk cap and contents.
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]  ring_head;
	logic [IDX_W-1:0]  ring_tail;
	logic              dma_busy;
	logic [LEN_W-1:0]  max_chunk_cfg;
	logic [DATA_W-1:0] ring_bytes [BUFFER_DEPTH];
	// Slots written at least once; only those may ever be fetched.
	bit                slot_filled [BUFFER_DEPTH];
	logic [IDX_W-1:0]  last_filled;
	// The chunk the DMA is currently working on, as last launched.
	logic [IDX_W-1:0]  chunk_ofs_now;
	int                chunk_len_now;

	chunker_result_t   pending_results [$];
	int                err_cnt;
	int                src_idle_pct;
	int                snk_idle_pct;
	int                stall_cnt;

	function automatic logic [7:0] rand8();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [11:0] rand12();
		return 12'($urandom_range(4095));
	endfunction

	// Work out the one result a request produces and advance the shadow state.
	function automatic chunker_result_t chunker_predict(kind_t kind, logic [7:0] data,
			logic [7:0] sent, logic [11:0] fidx);
		chunker_result_t  r;
		logic [IDX_W-1:0] nxt;
		logic [IDX_W-1:0] occ;
		logic [IDX_W-1:0] adv;
		logic             launch;
		int               run;
		int               cap;
		r = '0;
		launch = 1'b0;
		case (kind)
			KIND_ENQ: begin
				// One slot always stays free, so head+1 == tail means full.
				nxt = ring_head + IDX_W'(1);
				if (nxt != ring_tail) begin
					ring_bytes[ring_head] = data;
					slot_filled[ring_head] = 1'b1;
					last_filled = ring_head;
					ring_head = nxt;
					r.accepted = 1'b1;
				end
			end
			KIND_KICK: begin
				// Kick only launches from idle with data waiting.
				if (!dma_busy && ring_head != ring_tail) begin
					dma_busy = 1'b1;
					launch = 1'b1;
				end
			end
			KIND_DONE: begin
				// Done while idle is dropped; otherwise retire, clamped to occupancy.
				if (dma_busy) begin
					occ = ring_head - ring_tail;
					adv = (IDX_W'(sent) > occ) ? occ : IDX_W'(sent);
					ring_tail = ring_tail + adv;
					if (ring_head != ring_tail)
						launch = 1'b1;
					else
						dma_busy = 1'b0;
				end
			end
			KIND_FETCH: begin
				// The 12-bit index can not leave a 4096-deep ring.
				r.fetched_byte = ring_bytes[fidx];
			end
			default: begin
			end
		endcase
		if (launch) begin
			// Chunk ends at the head or at the buffer end; a zero cap acts as one.
			if (ring_head >= ring_tail)
				run = int'(ring_head - ring_tail);
			else
				run = BUFFER_DEPTH - int'(ring_tail);
			cap = (max_chunk_cfg == '0) ? 1 : int'(max_chunk_cfg);
			r.chunk_start = 1'b1;
			r.chunk_offset = ring_tail;
			r.chunk_length = LEN_W'((run > cap) ? cap : run);
			chunk_ofs_now = ring_tail;
			chunk_len_now = int'(r.chunk_length);
		end
		r.busy_res = dma_busy;
		r.occupancy = ring_head - ring_tail;
		return r;
	endfunction

	// A random slot that has been written, for fetches outside a chunk.
	function automatic logic [IDX_W-1:0] random_filled_slot();
		logic [IDX_W-1:0] i;
		repeat (32) begin
			i = IDX_W'($urandom_range(BUFFER_DEPTH - 1));
			if (slot_filled[i])
				return i;
		end
		return last_filled;
	endfunction

	// A slot inside the chunk in flight; every one of them holds queued data.
	function automatic logic [IDX_W-1:0] slot_in_chunk();
		return chunk_ofs_now + IDX_W'($urandom_range(chunk_len_now - 1));
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (err_cnt < REPORT_LINES)
			$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
				$time, what, got, want);
		err_cnt++;
	endtask

	// Offer one request, with random idle cycles in front of it per the sender
	// idle rate; once accepted, queue the result it must produce. valid stays
	// high after acceptance so back-to-back requests need no second assignment.
	task automatic send_request(kind_t kind, logic [7:0] data, logic [7:0] sent,
			logic [11:0] fidx);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.kind        <= kind;
		req_ch.data_byte   <= data;
		req_ch.amount_sent <= sent;
		req_ch.fetch_index <= fidx;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_results.push_back(chunker_predict(kind, data, sent, fidx));
	endtask

	task automatic send_enqueue(logic [7:0] data);
		send_request(KIND_ENQ, data, rand8(), rand12());
	endtask

	task automatic send_fetch(logic [11:0] fidx);
		send_request(KIND_FETCH, rand8(), rand8(), fidx);
	endtask

	// Stop sending and let every outstanding result come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// max_chunk may only change with nothing in flight.
	task automatic write_max_chunk(logic [7:0] value);
		drain_results();
		repeat (CFG_GUARD_CYCLES) @(posedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.max_chunk <= value;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		max_chunk_cfg = value;
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Corner cases on a nearly empty ring, then the cap at zero, one and 255.
	task automatic test_directed();
		send_request(KIND_KICK, 8'h00, 8'h00, 12'h000);   // kick on empty ring
		send_request(KIND_DONE, 8'hFF, 8'hFF, 12'hFFF);   // done while idle
		send_enqueue(8'h00);
		send_enqueue(8'hFF);
		send_enqueue(8'hA5);
		send_request(KIND_KICK, 8'h00, 8'h00, 12'h000);   // launches 0..2
		send_request(KIND_KICK, 8'h00, 8'h00, 12'h000);   // kick while busy
		send_fetch(12'h000);
		send_fetch(12'h001);
		send_request(KIND_DONE, 8'h00, 8'd1, 12'h000);    // partial, relaunch
		send_request(KIND_DONE, 8'h00, 8'hFF, 12'h000);   // more than held: clamp
		send_request(KIND_DONE, 8'h00, 8'h00, 12'h000);   // idle again, ignored

		write_max_chunk(8'd0);                              // zero cap behaves as one
		send_enqueue(8'h5A);
		send_enqueue(8'h3C);
		send_request(KIND_KICK, 8'h00, 8'h00, 12'h000);
		send_request(KIND_DONE, 8'h00, 8'd0, 12'h000);    // nothing sent: same chunk
		send_request(KIND_DONE, 8'h00, 8'd1, 12'h000);
		send_request(KIND_DONE, 8'h00, 8'd1, 12'h000);

		write_max_chunk(8'd1);
		send_enqueue(8'h81);
		send_enqueue(8'h7E);
		send_request(KIND_KICK, 8'h00, 8'h00, 12'h000);
		send_fetch(chunk_ofs_now);
		send_request(KIND_DONE, 8'h00, 8'd1, 12'h000);
		send_request(KIND_DONE, 8'h00, 8'd1, 12'h000);

		write_max_chunk(8'd255);
	endtask

	// Queue a batch larger than one chunk, then drain it chunk by chunk with
	// fetches inside each chunk and a trickle of new bytes behind it.
	task automatic test_chunk_drain();
		logic [IDX_W-1:0] occ;
		write_max_chunk(8'd100);
		occ = ring_head - ring_tail;
		while (occ < IDX_W'(150)) begin
			send_enqueue(rand8());
			occ = ring_head - ring_tail;
		end
		send_request(KIND_KICK, rand8(), rand8(), rand12());
		while (dma_busy) begin
			send_fetch(slot_in_chunk());
			if ($urandom_range(3) == 0)
				send_enqueue(rand8());
			send_request(KIND_DONE, rand8(), 8'(chunk_len_now), rand12());
		end
	endtask

	// Producer/DMA traffic: enqueue bursts, kicks, fetches inside the chunk and
	// done reports that mostly match the chunk, mixed with a little noise.
	// Only requests that change or read something count toward the target.
	task automatic test_random_traffic(int target);
		int    counted;
		int    pick;
		int    n;
		int    amt;
		kind_t k;
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				n = $urandom_range(1, 12);
				repeat (n) send_enqueue(rand8());
				counted += n;
			end else if (pick < 55) begin
				if (!dma_busy && ring_head != ring_tail)
					counted++;
				send_request(KIND_KICK, rand8(), rand8(), rand12());
			end else if (pick < 70) begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_fetch(dma_busy ? slot_in_chunk() : random_filled_slot());
				counted += n;
			end else if (pick < 90) begin
				if (dma_busy) begin
					// Mostly the full chunk, sometimes short, sometimes too much.
					n = $urandom_range(99);
					if (n < 70)
						amt = chunk_len_now;
					else if (n < 85)
						amt = $urandom_range(chunk_len_now);
					else if (n < 95)
						amt = $urandom_range(255, chunk_len_now);
					else
						amt = $urandom_range(255);
					counted++;
				end else begin
					amt = $urandom_range(255);
				end
				send_request(KIND_DONE, rand8(), 8'(amt), rand12());
			end else begin
				// Noise: any kind with arbitrary fields, fetches still on written slots.
				k = kind_t'($urandom_range(3));
				send_request(k, rand8(), rand8(), random_filled_slot());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure and the in-order check.
	// ------------------------------------------------------------------
	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

	always @(posedge clk) begin : result_check
		chunker_result_t seen;
		chunker_result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			seen = {res_ch.accepted, res_ch.chunk_start, res_ch.chunk_offset,
				res_ch.chunk_length, res_ch.busy_res, res_ch.fetched_byte,
				res_ch.occupancy};
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", seen, 0);
			end else begin
				want = pending_results.pop_front();
				if (seen.accepted !== want.accepted)
					report_mismatch("accepted", seen.accepted, want.accepted);
				if (seen.chunk_start !== want.chunk_start)
					report_mismatch("chunk_start", seen.chunk_start, want.chunk_start);
				if (seen.chunk_offset !== want.chunk_offset)
					report_mismatch("chunk_offset", seen.chunk_offset, want.chunk_offset);
				if (seen.chunk_length !== want.chunk_length)
					report_mismatch("chunk_length", seen.chunk_length, want.chunk_length);
				if (seen.busy_res !== want.busy_res)
					report_mismatch("busy_res", seen.busy_res, want.busy_res);
				if (seen.fetched_byte !== want.fetched_byte)
					report_mismatch("fetched_byte", seen.fetched_byte, want.fetched_byte);
				if (seen.occupancy !== want.occupancy)
					report_mismatch("occupancy", seen.occupancy, want.occupancy);
			end
		end
	end

	// Watchdog: any request, result or config write accepted resets the count.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.kind        <= KIND_ENQ;
		req_ch.data_byte   <= '0;
		req_ch.amount_sent <= '0;
		req_ch.fetch_index <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.max_chunk   <= MAX_CHUNK_RST;
		ring_head     = '0;
		ring_tail     = '0;
		dma_busy      = 1'b0;
		max_chunk_cfg = MAX_CHUNK_RST;
		last_filled   = '0;
		chunk_ofs_now = '0;
		chunk_len_now = 1;
		err_cnt       = 0;
		// Sender idles 28%, receiver 45% for the first stretch.
		src_idle_pct  = 28;
		snk_idle_pct  = 45;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_chunk_drain();
		write_max_chunk(8'($urandom_range(2, 254)));
		test_random_traffic(220);

		// Swap the idle rates.
		src_idle_pct = 45;
		snk_idle_pct = 28;
		write_max_chunk(8'($urandom_range(1, 8)));
		test_random_traffic(220);

		// Full rate both ways, full cap.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_max_chunk(8'd255);
		test_random_traffic(220);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/txrc_pkg.sv
sv/txrc_if.sv
sv/txrc_ram.sv
sv/txrc_front.sv
sv/txrc_back.sv
sv/tx_ring_dma_chunker.sv
sim/testbench.sv
